// File: hw/rtl/pdcp_pkg.sv
// ---------------------------------------------------------------------------
// PDCP receive reordering package
// Shared payload types, result codes, sizes and controller states.
// ---------------------------------------------------------------------------
`default_nettype none
package pdcp_pkg;

  // Sequence number width and reorder store depth; the payload types and
  // the slot indexing are built for these values.
  localparam int SN_BITS     = 12;
  localparam int STORE_DEPTH = 64;

  typedef struct packed {
    logic        op;
    logic [11:0] seq_num;
    logic [15:0] pdu_handle;
  } pdcp_in_t;

  typedef struct packed {
    logic [15:0] out_handle;
    logic [11:0] out_seq_num;
    logic [19:0] out_hfn;
    logic [1:0]  status;
    logic        last;
  } pdcp_out_t;

  localparam logic [1:0] ST_DELIVERED = 2'd0;
  localparam logic [1:0] ST_DISCARD   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic       OP_PDU  = 1'b0;
  localparam logic       OP_TICK = 1'b1;

  localparam logic [0:0] REG_ENABLE  = 1'd0;
  localparam logic [0:0] REG_TIMEOUT = 1'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_EXP_LOW,
    S_RUN,
    S_FINISH,
    S_OUT
  } pdcp_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the accepted request
    logic tick;        // apply a tick that did not expire
    logic pass_emit;   // emit the pending non-stored result
    logic arrive_store;// classify result: store the arrival
    logic expire_init; // begin expiry scan
    logic scan_step;   // examine one slot of the scan
    logic run_step;    // examine one slot of the in-order run
    logic finish;      // timer bookkeeping at end of request
    logic emit_take;   // output register taken
  } pdcp_cmd_t;

  // Status back from the datapath.
  typedef struct packed {
    logic is_tick;
    logic expire_now;
    logic timer_running;
    logic reject;      // arrival gives one immediate result
    logic in_order;    // stored arrival starts a run
    logic low_done;    // low part of expiry scan finished
    logic run_done;    // in-order run finished
    logic slot_hit;    // the current scan slot delivers
    logic out_full;    // output register holds a result
  } pdcp_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/pdcp_datapath.sv
// ---------------------------------------------------------------------------
// PDCP reordering datapath
// Reorder store, sequence state, timer and output register.
// ---------------------------------------------------------------------------
`default_nettype none
module pdcp_datapath
  import pdcp_pkg::*;
#(
  parameter int WINDOW      = 2048
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire pdcp_cmd_t  cmd,
  output pdcp_stat_t      stat,
  input  wire pdcp_in_t   in_data,
  input  wire logic       reorder_enable,
  input  wire logic [15:0] timeout_ticks,
  output pdcp_out_t       out_data,
  output logic            out_valid
);

  localparam int IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH + 1) : 1;
  localparam logic [SN_BITS-1:0] SN_MAX = {SN_BITS{1'b1}};
  localparam logic [SN_BITS:0] WIN_S = (SN_BITS+1)'(WINDOW > (1 << SN_BITS) ?
                                       (1 << SN_BITS) : WINDOW);

  logic [STORE_DEPTH-1:0] valid_r, valid_nxt;
  logic [15:0] hmem [STORE_DEPTH];
  logic [19:0] fmem [STORE_DEPTH];

  logic [SN_BITS-1:0] lds_r, lds_nxt, nes_r, nes_nxt, rsn_r, rsn_nxt;
  logic [19:0] hfn_r, hfn_nxt;
  logic run_r, run_nxt, hit_r, hit_nxt;
  logic [15:0] left_r, left_nxt;
  logic op_r;
  logic [SN_BITS-1:0] sn_r;
  logic [15:0] h_r;
  logic [SN_BITS-1:0] cur_r, cur_nxt;   // scan sequence number
  logic [CW-1:0] k_r, k_nxt;
  logic [SN_BITS-1:0] rlim_r, rlim_nxt;
  logic wr_en;
  logic [19:0] wr_hfn;
  logic [15:0] rdh_r;
  logic [19:0] rdf_r;
  pdcp_out_t ob_r, ob_nxt;
  logic ov_r, ov_nxt;

  logic [SN_BITS-1:0] sn_in;
  logic signed [SN_BITS+1:0] da, db, dn;
  logic [SN_BITS-1:0] sn_gap;
  logic [IW-1:0] sidx, cidx, nidx;
  logic is_stale, is_full, is_dup;

  assign sn_in = in_data.seq_num[SN_BITS-1:0];
  assign sidx = sn_r[IW-1:0];
  assign cidx = cur_r[IW-1:0];
  assign nidx = cur_nxt[IW-1:0];
  assign da = $signed({2'b00, sn_r}) - $signed({2'b00, lds_r});
  assign db = -da;
  assign dn = $signed({2'b00, nes_r}) - $signed({2'b00, sn_r});
  assign sn_gap = sn_r - lds_r - 1'b1;
  assign is_stale = (da > $signed({1'b0, WIN_S})) ||
                    (db >= 0 && db < $signed({1'b0, WIN_S}));
  assign is_full = {1'b0, sn_gap} >= (SN_BITS+1)'(STORE_DEPTH);
  assign is_dup = valid_r[sidx];

  always_comb begin
    stat = '0;
    stat.is_tick       = op_r;
    stat.expire_now    = run_r && (left_r <= 16'd1);
    stat.timer_running = run_r;
    stat.reject        = !reorder_enable || is_stale || is_full || is_dup;
    stat.in_order      = (sn_r == lds_r + 1'b1);
    stat.low_done      = (k_r >= CW'(STORE_DEPTH)) || (SN_BITS'(k_r) >= rlim_r);
    stat.run_done      = (k_r >= CW'(STORE_DEPTH)) || !valid_r[cidx];
    stat.slot_hit      = valid_r[cidx];
    stat.out_full      = ov_r;
  end

  always_comb begin
    valid_nxt = valid_r;
    lds_nxt = lds_r; nes_nxt = nes_r; hfn_nxt = hfn_r; rsn_nxt = rsn_r;
    run_nxt = run_r; left_nxt = left_r; hit_nxt = hit_r;
    cur_nxt = cur_r; k_nxt = k_r; rlim_nxt = rlim_r;
    ob_nxt = ob_r; ov_nxt = ov_r;
    wr_en = 1'b0; wr_hfn = hfn_r;
    if (cmd.emit_take) ov_nxt = 1'b0;
    if (cmd.tick) left_nxt = left_r - 16'd1;
    if (cmd.pass_emit) begin
      ob_nxt.out_handle  = h_r;
      ob_nxt.out_seq_num = 12'(sn_r);
      ob_nxt.last        = 1'b1;
      if (!reorder_enable) begin
        ob_nxt.out_hfn = hfn_r; ob_nxt.status = ST_DELIVERED;
      end else begin
        ob_nxt.out_hfn = '0;
        ob_nxt.status = (is_stale || (!is_full && is_dup)) ? ST_DISCARD : ST_FULL;
      end
      ov_nxt = 1'b1;
    end
    if (cmd.arrive_store) begin
      wr_en = 1'b1;
      valid_nxt[sidx] = 1'b1;
      hit_nxt = 1'b0;
      if (dn > $signed({1'b0, WIN_S})) begin
        hfn_nxt = hfn_r + 20'd1; wr_hfn = hfn_r + 20'd1; nes_nxt = sn_r + 1'b1;
      end else if (-dn >= $signed({1'b0, WIN_S})) begin
        wr_hfn = hfn_r - 20'd1;
      end else if (sn_r >= nes_r) begin
        nes_nxt = sn_r + 1'b1;
        if (sn_r == SN_MAX) hfn_nxt = hfn_r + 20'd1;
      end
      cur_nxt = sn_r; k_nxt = '0;
    end
    if (cmd.expire_init) begin
      run_nxt = 1'b0;
      cur_nxt = lds_r + 1'b1;
      rlim_nxt = rsn_r - lds_r - 1'b1;
      k_nxt = '0;
    end
    if (cmd.scan_step || cmd.run_step) begin
      if (valid_r[cidx]) begin
        ob_nxt.out_handle  = rdh_r;
        ob_nxt.out_seq_num = 12'(cur_r);
        ob_nxt.out_hfn     = rdf_r;
        ob_nxt.status      = ST_DELIVERED;
        ob_nxt.last        = 1'b0;
        ov_nxt = 1'b1;
        valid_nxt[cidx] = 1'b0;
        lds_nxt = cur_r;
        if (cmd.run_step && cur_r == rsn_r - 1'b1) hit_nxt = 1'b1;
      end
      cur_nxt = cur_r + 1'b1;
      k_nxt = k_r + 1'b1;
    end
    if (cmd.finish) begin
      if (run_r && hit_r && !op_r) run_nxt = 1'b0;
      if ((!run_r || (hit_r && !op_r) || op_r) && (valid_nxt != '0) &&
          !(run_r && !(hit_r && !op_r) && !op_r)) begin
        run_nxt = 1'b1;
        left_nxt = timeout_ticks;
        rsn_nxt = nes_r;
      end
      hit_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0; lds_r <= SN_MAX; nes_r <= '0; hfn_r <= '0; rsn_r <= '0;
      run_r <= 1'b0; left_r <= '0; hit_r <= 1'b0; ov_r <= 1'b0;
      k_r <= '0; cur_r <= '0; rlim_r <= '0;
    end else begin
      valid_r <= valid_nxt; lds_r <= lds_nxt; nes_r <= nes_nxt; hfn_r <= hfn_nxt;
      rsn_r <= rsn_nxt; run_r <= run_nxt; left_r <= left_nxt; hit_r <= hit_nxt;
      ov_r <= ov_nxt; k_r <= k_nxt; cur_r <= cur_nxt; rlim_r <= rlim_nxt;
    end
  end

  // The slot read is registered at the next scan address, so the data of the
  // slot under cur_r is ready when it is examined. A write to that same slot
  // is forwarded.
  always_ff @(posedge clk) begin
    ob_r <= ob_nxt;
    if (cmd.load) begin
      op_r <= in_data.op; sn_r <= sn_in; h_r <= in_data.pdu_handle;
    end
    if (wr_en) begin
      hmem[sidx] <= h_r;
      fmem[sidx] <= wr_hfn;
    end
    if (wr_en && sidx == nidx) begin
      rdh_r <= h_r;
      rdf_r <= wr_hfn;
    end else begin
      rdh_r <= hmem[nidx];
      rdf_r <= fmem[nidx];
    end
  end

  // Output register drives the port; only non-stored results set last here.
  always_comb begin
    out_data = ob_r;
  end
  assign out_valid = ov_r;

endmodule
`default_nettype wire

// File: hw/rtl/pdcp_ctrl.sv
// ---------------------------------------------------------------------------
// PDCP reordering controller
// Sequences one request at a time through classify, scan and run phases.
// ---------------------------------------------------------------------------
`default_nettype none
module pdcp_ctrl
  import pdcp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       out_stall,
  output logic            mark_last,
  output logic            out_release,
  input  wire pdcp_stat_t stat,
  output pdcp_cmd_t       cmd
);

  pdcp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // Scan and run steps that emit wait until the output register is free.
  // A held result is shown only once it is known whether another result of
  // the same request follows it.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    mark_last = 1'b0;
    out_release = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.is_tick) begin
          if (!stat.timer_running) state_nxt = S_IDLE;
          else if (stat.expire_now) begin
            cmd.expire_init = 1'b1; state_nxt = S_EXP_LOW;
          end else begin
            cmd.tick = 1'b1; state_nxt = S_IDLE;
          end
        end else if (stat.reject) begin
          if (!stat.out_full || !out_stall) begin
            cmd.pass_emit = 1'b1; state_nxt = S_OUT;
          end
        end else begin
          cmd.arrive_store = 1'b1;
          state_nxt = stat.in_order ? S_RUN : S_FINISH;
        end
      end
      S_EXP_LOW: begin
        out_release = !stat.low_done && stat.slot_hit;
        if (stat.low_done) state_nxt = S_RUN;
        else if (!stat.slot_hit || !stat.out_full || !out_stall) cmd.scan_step = 1'b1;
      end
      S_RUN: begin
        out_release = !stat.run_done;
        if (stat.run_done) state_nxt = S_FINISH;
        else if (!stat.out_full || !out_stall) cmd.run_step = 1'b1;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        mark_last = 1'b1;
        out_release = 1'b1;
        if (!stat.out_full || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.emit_take = stat.out_full && out_release && !out_stall;
  end

endmodule
`default_nettype wire

// File: hw/rtl/pdcp_rx_reordering.sv
// A rejected or pass-through arrival is classified in S_EVAL, its result is registered in the
// output register and released in S_OUT. Requests are worked one at a time: a tick, an arrival
// and any in-order run or expiry scan that it starts all finish before the next request is
// taken, and receiver stalls can hold the work.
// Reset (synchronous, rst_n low) clears the store valid bits, sequence state,
// timer, output valid and configuration registers to their defaults.
// ---------------------------------------------------------------------------
// PDCP receive reordering top level
// Configuration port, controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none
module pdcp_rx_reordering
  import pdcp_pkg::*;
#(
  parameter int WINDOW      = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire pdcp_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output pdcp_out_t        out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  pdcp_cmd_t  cmd;
  pdcp_stat_t stat;
  pdcp_out_t  dp_out;
  logic en_r, mark_last, out_release, dp_valid;
  logic [15:0] to_r;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0; to_r <= 16'd100;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[2])
        REG_ENABLE:  en_r <= cfg_pwdata[0];
        REG_TIMEOUT: to_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr[2])
      REG_ENABLE:  cfg_prdata = {31'd0, en_r};
      REG_TIMEOUT: cfg_prdata = {16'd0, to_r};
      default:     cfg_prdata = '0;
    endcase
  end

  pdcp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .mark_last(mark_last), .out_release(out_release),
    .stat(stat), .cmd(cmd)
  );

  pdcp_datapath #(.WINDOW(WINDOW)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_data(in_data),
    .reorder_enable(en_r), .timeout_ticks(to_r), .out_data(dp_out), .out_valid(dp_valid)
  );

  // A held result becomes last once the controller reaches the end of its request.
  assign out_valid = dp_valid && out_release;
  always_comb begin
    out_data = dp_out;
    out_data.last = dp_out.last | mark_last;
  end

endmodule
`default_nettype wire

// File: hw/rtl/pdcp_checker.sv
// ---------------------------------------------------------------------------
// PDCP reordering port checker
// Port-level properties of the reordering block.
// ---------------------------------------------------------------------------
`default_nettype none
module pdcp_port_sva
  import pdcp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire pdcp_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data.out_handle))
    else $error("stalled result changed");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("bad status code");

  a_reject_zero_hfn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_DELIVERED |-> out_data.out_hfn == '0)
    else $error("rejected result carries hfn");

  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken during work");

endmodule

bind pdcp_rx_reordering pdcp_port_sva u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

// File: dv/pdcp_checker.sv
// ---------------------------------------------------------------------------
// PDCP receive reordering checker
// Watches the request, result and configuration ports of the block, predicts
// every result from its own model of the reordering state and compares.
// ---------------------------------------------------------------------------
`default_nettype none
module pdcp_checker
  import pdcp_pkg::*;
#(
  parameter int WINDOW      = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire pdcp_in_t    in_data,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire pdcp_out_t   out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               fail_count,
  output int               pending
);

  localparam bit [31:0] SN_MASK = (32'd1 << SN_BITS) - 32'd1;

  pdcp_out_t  expected_results[$];

  bit [31:0]  last_sn;
  bit [31:0]  next_sn;
  bit [19:0]  cur_hfn;
  bit [31:0]  reorder_count;
  bit         timer_on;
  bit [15:0]  ticks_left;
  bit         slot_used [STORE_DEPTH];
  bit [15:0]  slot_tag  [STORE_DEPTH];
  bit [19:0]  slot_hfnv [STORE_DEPTH];
  bit         enable_q;
  bit [15:0]  timeout_q;
  pdcp_out_t  step_results[$];

  task automatic report(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic void push_result(bit [15:0] h, bit [31:0] sn, bit [19:0] hfn,
                                      logic [1:0] st);
    pdcp_out_t r;
    r.out_handle  = h;
    r.out_seq_num = sn[11:0];
    r.out_hfn     = hfn;
    r.status      = st;
    r.last        = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void release_slot(bit [31:0] sn);
    int i;
    i = sn % STORE_DEPTH;
    push_result(slot_tag[i], sn, slot_hfnv[i], ST_DELIVERED);
    slot_used[i] = 1'b0;
    last_sn = sn;
  endfunction

  function automatic bit store_busy();
    for (int i = 0; i < STORE_DEPTH; i++) if (slot_used[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void arm_timer();
    reorder_count = ({12'd0, cur_hfn} << SN_BITS) | next_sn;
    timer_on = 1'b1;
    ticks_left = timeout_q;
  endfunction

  function automatic void timer_expiry();
    bit [31:0] base, span, s;
    base = (last_sn + 1) & SN_MASK;
    span = ((reorder_count & SN_MASK) - base) & SN_MASK;
    timer_on = 1'b0;
    for (int k = 0; k < STORE_DEPTH && k < span; k++) begin
      s = (base + k) & SN_MASK;
      if (slot_used[s % STORE_DEPTH]) release_slot(s);
    end
    for (int k = span; k < STORE_DEPTH; k++) begin
      s = (base + k) & SN_MASK;
      if (!slot_used[s % STORE_DEPTH]) break;
      release_slot(s);
    end
    if (store_busy()) arm_timer();
  endfunction

  function automatic void pdu_arrival(bit [31:0] sn, bit [15:0] h);
    int        ahead, behind, idx, k;
    bit [19:0] hfn;
    bit [31:0] stop, s;
    bit        hit;
    ahead  = int'(sn) - int'(last_sn);
    behind = -ahead;
    hit    = 1'b0;
    if (ahead > WINDOW || (behind >= 0 && behind < WINDOW)) begin
      push_result(h, sn, 20'd0, ST_DISCARD);
      return;
    end
    if (((sn - last_sn - 1) & SN_MASK) >= STORE_DEPTH) begin
      push_result(h, sn, 20'd0, ST_FULL);
      return;
    end
    idx = sn % STORE_DEPTH;
    if (slot_used[idx]) begin
      push_result(h, sn, 20'd0, ST_DISCARD);
      return;
    end
    if (int'(next_sn) - int'(sn) > WINDOW) begin
      cur_hfn = cur_hfn + 1;
      hfn = cur_hfn;
      next_sn = (sn + 1) & SN_MASK;
    end else if (int'(sn) - int'(next_sn) >= WINDOW) begin
      hfn = cur_hfn - 1;
    end else if (sn >= next_sn) begin
      hfn = cur_hfn;
      if (sn + 1 > SN_MASK) begin
        next_sn = 0;
        cur_hfn = cur_hfn + 1;
      end else begin
        next_sn = sn + 1;
      end
    end else begin
      hfn = cur_hfn;
    end
    slot_used[idx] = 1'b1;
    slot_tag[idx]  = h;
    slot_hfnv[idx] = hfn;
    if (sn == ((last_sn + 1) & SN_MASK)) begin
      stop = ((reorder_count & SN_MASK) - 1) & SN_MASK;
      s = sn;
      for (k = 0; k < STORE_DEPTH && slot_used[s % STORE_DEPTH]; k++) begin
        release_slot(s);
        if (s == stop) hit = 1'b1;
        s = (s + 1) & SN_MASK;
      end
    end
    if (timer_on && hit) timer_on = 1'b0;
    if (!timer_on && store_busy()) arm_timer();
  endfunction

  function automatic void predict_request(pdcp_in_t req);
    bit [31:0] sn;
    sn = {20'd0, req.seq_num} & SN_MASK;
    step_results.delete();
    if (req.op == OP_TICK) begin
      if (timer_on) begin
        if (ticks_left <= 1) timer_expiry();
        else ticks_left--;
      end
    end else if (!enable_q) begin
      push_result(req.pdu_handle, sn, cur_hfn, ST_DELIVERED);
    end else begin
      pdu_arrival(sn, req.pdu_handle);
    end
    if (step_results.size() > 0) step_results[$].last = 1'b1;
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  always @(posedge clk) begin
    pdcp_out_t want;
    if (!rst_n) begin
      last_sn = SN_MASK;
      next_sn = 0;
      cur_hfn = 0;
      reorder_count = 0;
      timer_on = 1'b0;
      ticks_left = 0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        slot_used[i] = 1'b0;
        slot_tag[i]  = 0;
        slot_hfnv[i] = 0;
      end
      enable_q = 1'b0;
      timeout_q = 16'd100;
      expected_results.delete();
    end else begin
      // A result and the request that follows it may share an edge; the
      // result always belongs to an earlier request, so compare first.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result %p", out_data));
        end else begin
          want = expected_results.pop_front();
          if (out_data.out_handle !== want.out_handle)
            report($sformatf("handle %h, expected %h", out_data.out_handle,
                             want.out_handle));
          if (out_data.out_seq_num !== want.out_seq_num)
            report($sformatf("seq_num %h, expected %h", out_data.out_seq_num,
                             want.out_seq_num));
          if (out_data.out_hfn !== want.out_hfn)
            report($sformatf("hfn %h, expected %h", out_data.out_hfn, want.out_hfn));
          if (out_data.status !== want.status)
            report($sformatf("status %0d, expected %0d", out_data.status, want.status));
          if (out_data.last !== want.last)
            report($sformatf("last %b, expected %b", out_data.last, want.last));
        end
      end
      if (in_valid && !in_stall) predict_request(in_data);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_TIMEOUT) timeout_q = cfg_pwdata[15:0];
        else enable_q = cfg_pwdata[0];
      end
    end
    pending = expected_results.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

endmodule
`default_nettype wire

// File: dv/tb.sv
// ---------------------------------------------------------------------------
// PDCP receive reordering testbench
// Directed special cases, then random bursts of arrivals and ticks under
// several register settings, with random sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
`default_nettype none
module tb;
  import pdcp_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  pdcp_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  pdcp_out_t   out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          pending;
  int          cycles;
  int          stall_mode;
  bit [11:0]   sn_front;

  pdcp_rx_reordering dut (.*);
  pdcp_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("pdcp_rx_reordering test failed");
        $finish;
      end
    end
  end

  // Receiver stall pattern: free-running, bursty or heavy, switching now and then.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic reg_write(input logic [0:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every expected result, then let a possible expiry scan finish.
  task automatic wait_quiet();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input bit enable, input logic [15:0] timeout);
    wait_quiet();
    reg_write(REG_ENABLE, {31'd0, enable});
    reg_write(REG_TIMEOUT, {16'd0, timeout});
  endtask

  // Present one request, held until accepted; stall is read mid-cycle.
  task automatic send(input logic op, input logic [11:0] sn, input logic [15:0] h);
    bit stalled;
    in_valid           <= 1'b1;
    in_data.op         <= op;
    in_data.seq_num    <= sn;
    in_data.pdu_handle <= h;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_one(input logic op, input logic [11:0] sn, input logic [15:0] h);
    send(op, sn, h);
    idle_sender($urandom_range(1, 2));
  endtask

  // Mostly near-in-order arrivals around a moving front, with ticks, forward
  // jumps and fully random sequence numbers mixed in.
  task automatic random_phase(input int count);
    int n, r, gap;
    logic [11:0] sn;
    n = 0;
    while (n < count) begin
      for (int b = $urandom_range(1, 12); b > 0 && n < count; b--) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          send(OP_TICK, 12'($urandom), 16'($urandom));
        end else begin
          if (r < 38) sn = 12'($urandom);
          else if (r < 45) begin
            sn = sn_front + 12'($urandom_range(20, 63));
            sn_front = sn;
          end else begin
            sn = sn_front + 12'($urandom_range(0, 10));
            sn_front = sn_front + 12'($urandom_range(0, 2));
          end
          send(OP_PDU, sn, 16'($urandom));
        end
        n++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      idle_sender(gap);
    end
    idle_sender(1);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    sn_front    = 12'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reordering off after reset: everything passes straight through.
    send_one(OP_PDU, 12'h000, 16'hFFFF);
    send_one(OP_PDU, 12'hFFF, 16'h0000);
    send_one(OP_TICK, 12'h000, 16'h0000);

    configure(1'b1, 16'd2);
    send_one(OP_PDU, 12'h000, 16'h1111);  // in order, delivered
    send_one(OP_PDU, 12'h000, 16'h2222);  // stale
    send_one(OP_PDU, 12'h002, 16'h3333);  // stored, timer starts
    send_one(OP_PDU, 12'h002, 16'h4444);  // duplicate
    send_one(OP_PDU, 12'h041, 16'h5555);  // past the store depth
    send_one(OP_PDU, 12'h001, 16'h6666);  // fills the gap, run of two
    send_one(OP_PDU, 12'h005, 16'h7777);
    send_one(OP_TICK, 12'hABC, 16'hABCD);
    send_one(OP_TICK, 12'h123, 16'h4321); // expiry
    send_one(OP_TICK, 12'h000, 16'h0000); // timer idle
    send_one(OP_PDU, 12'h807, 16'h8888);  // too far ahead
    send_one(OP_PDU, 12'h044, 16'h9999);  // stored, one slot short of the farthest
    send_one(OP_PDU, 12'h00A, 16'hAAAA);

    // Disabled while entries are still stored: ticks still drain them.
    configure(1'b0, 16'd1);
    send_one(OP_PDU, 12'h300, 16'hBBBB);
    send_one(OP_TICK, 12'h000, 16'h0000);
    send_one(OP_TICK, 12'h000, 16'h0000);

    configure(1'b1, 16'd1);
    sn_front = 12'h045;
    random_phase(70);
    configure(1'b1, 16'd4);
    random_phase(70);
    configure(1'b1, 16'hFFFF);
    random_phase(30);
    configure(1'b0, 16'd3);
    random_phase(30);
    configure(1'b1, 16'($urandom_range(1, 6)));
    random_phase(110);

    wait_quiet();
    if (fail_count == 0) begin
      $display("pdcp_rx_reordering test passed");
    end else begin
      $display("pdcp_rx_reordering test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
hw/rtl/pdcp_pkg.sv
hw/rtl/pdcp_datapath.sv
hw/rtl/pdcp_ctrl.sv
hw/rtl/pdcp_rx_reordering.sv
hw/rtl/pdcp_checker.sv
dv/pdcp_checker.sv
dv/tb.sv
